@@ src/pld3_pkg.sv @@
`timescale 1ns / 1ps
package pld3_pkg;
	localparam int COORD_W   = 32;
	localparam int IN_FRAC   = 16;
	localparam int FRAC_BITS = 16;
	localparam int DIST_BITS = 34;

	localparam int V_W    = COORD_W + 1;
	localparam int PROD_W = COORD_W + V_W;
	localparam int C_W    = PROD_W + 1;
	localparam int MAG_W  = C_W - 1;
	localparam int LO_W   = COORD_W;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int SC_W   = 2 * MAG_W;
	localparam int SD_W   = 2 * COORD_W;

	// fraction alignment, applied to one side of the compare
	localparam int SHR = (FRAC_BITS >= IN_FRAC) ? 2 * (FRAC_BITS - IN_FRAC) : 0;
	localparam int SHL = (FRAC_BITS >= IN_FRAC) ? 0 : 2 * (IN_FRAC - FRAC_BITS);
	localparam int RHS_W = SC_W + SHR;
	localparam int LHS_W = SD_W + SHL;
	localparam int WK_W  = ((RHS_W > 2 * DIST_BITS + LHS_W) ? RHS_W
		: 2 * DIST_BITS + LHS_W) + 2;

	localparam int FRONT_ST  = 6;
	localparam int SEARCH_ST = DIST_BITS + 1;
	localparam int NST       = FRONT_ST + SEARCH_ST;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0] mag_t;
endpackage

@@ src/pld3_cross.sv @@
`timescale 1ns / 1ps
module pld3_cross import pld3_pkg::*; (
	input  logic        clk,
	input  logic [2:0]  en,
	input  coord_t      point_x,
	input  coord_t      point_y,
	input  coord_t      point_z,
	input  coord_t      line_x,
	input  coord_t      line_y,
	input  coord_t      line_z,
	input  coord_t      dir_x,
	input  coord_t      dir_y,
	input  coord_t      dir_z,
	output mag_t        cmag_s3 [3],
	output logic [SD_W-1:0] sd_s3,
	output logic        deg_s3
);
	logic signed [V_W-1:0]    v_s1 [3];
	coord_t                   d_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [6];
	logic [SD_W-1:0]          dsq_s2 [3];
	logic signed [C_W-1:0]    c [3];
	logic [SD_W-1:0]          sd_sum;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1[0] <= V_W'(line_x) - V_W'(point_x);
			v_s1[1] <= V_W'(line_y) - V_W'(point_y);
			v_s1[2] <= V_W'(line_z) - V_W'(point_z);
			d_s1[0] <= dir_x;
			d_s1[1] <= dir_y;
			d_s1[2] <= dir_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2[0] <= PROD_W'(d_s1[1]) * PROD_W'(v_s1[2]);
			p_s2[1] <= PROD_W'(d_s1[2]) * PROD_W'(v_s1[1]);
			p_s2[2] <= PROD_W'(d_s1[2]) * PROD_W'(v_s1[0]);
			p_s2[3] <= PROD_W'(d_s1[0]) * PROD_W'(v_s1[2]);
			p_s2[4] <= PROD_W'(d_s1[0]) * PROD_W'(v_s1[1]);
			p_s2[5] <= PROD_W'(d_s1[1]) * PROD_W'(v_s1[0]);
			for (int i = 0; i < 3; i++) begin
				dsq_s2[i] <= SD_W'(SD_W'(d_s1[i]) * SD_W'(d_s1[i]));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c[i] = C_W'(p_s2[2*i]) - C_W'(p_s2[2*i+1]);
		end
		sd_sum = dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				cmag_s3[i] <= c[i][C_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
			end
			sd_s3  <= sd_sum;
			deg_s3 <= (sd_sum == '0);
		end
	end
endmodule

@@ src/pld3_square.sv @@
`timescale 1ns / 1ps
module pld3_square import pld3_pkg::*; (
	input  logic            clk,
	input  logic [2:0]      en,
	input  mag_t            cmag_s3 [3],
	input  logic [SD_W-1:0] sd_s3,
	input  logic            deg_s3,
	output logic [SC_W-1:0] sc_s6,
	output logic [SD_W-1:0] sd_s6,
	output logic            deg_s6
);
	logic [2*HI_W-1:0]      hh_s4 [3];
	logic [HI_W+LO_W-1:0]   hl_s4 [3];
	logic [2*LO_W-1:0]      ll_s4 [3];
	logic [SC_W-1:0]        sq_s5 [3];
	logic [SD_W-1:0]        sd_s4, sd_s5;
	logic                   deg_s4, deg_s5;

	// |C|^2 split as hi/lo halves so each product stays near 32x32
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				hh_s4[i] <= (2*HI_W)'(cmag_s3[i][MAG_W-1:LO_W])
					* (2*HI_W)'(cmag_s3[i][MAG_W-1:LO_W]);
				hl_s4[i] <= (HI_W+LO_W)'(cmag_s3[i][MAG_W-1:LO_W])
					* (HI_W+LO_W)'(cmag_s3[i][LO_W-1:0]);
				ll_s4[i] <= (2*LO_W)'(cmag_s3[i][LO_W-1:0])
					* (2*LO_W)'(cmag_s3[i][LO_W-1:0]);
			end
			sd_s4  <= sd_s3;
			deg_s4 <= deg_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= (SC_W'(hh_s4[i]) << (2*LO_W))
					+ (SC_W'(hl_s4[i]) << (LO_W+1)) + SC_W'(ll_s4[i]);
			end
			sd_s5  <= sd_s4;
			deg_s5 <= deg_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sc_s6  <= sq_s5[0] + sq_s5[1] + sq_s5[2];
			sd_s6  <= sd_s5;
			deg_s6 <= deg_s5;
		end
	end
endmodule

@@ src/pld3_search.sv @@
`timescale 1ns / 1ps
module pld3_search import pld3_pkg::*; (
	input  logic                 clk,
	input  logic [SEARCH_ST-1:0] en,
	input  logic [SC_W-1:0]      sc_s6,
	input  logic [SD_W-1:0]      sd_s6,
	input  logic                 deg_s6,
	output logic [DIST_BITS-1:0] distance,
	output logic                 degenerate,
	output logic                 saturated
);
	// E = rhs - q^2*lhs, F = q*lhs; one quotient bit per stage
	logic [WK_W-1:0]      e_s   [SEARCH_ST];
	logic [WK_W-1:0]      f_s   [SEARCH_ST];
	logic [WK_W-1:0]      lhs_s [SEARCH_ST];
	logic [DIST_BITS-1:0] q_s   [SEARCH_ST];
	logic                 deg_s [SEARCH_ST];
	logic                 sat_s [SEARCH_ST];
	logic [WK_W-1:0]      rhs0, lhs0;

	always_comb begin
		rhs0 = WK_W'(sc_s6) << SHR;
		lhs0 = WK_W'(sd_s6) << SHL;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			e_s[0]   <= rhs0;
			f_s[0]   <= '0;
			lhs_s[0] <= lhs0;
			q_s[0]   <= '0;
			deg_s[0] <= deg_s6;
			sat_s[0] <= !deg_s6 && ((lhs0 << (2*DIST_BITS)) <= rhs0);
		end
	end

	for (genvar j = 1; j < SEARCH_ST; j++) begin : g_bit
		localparam int B = DIST_BITS - j;
		logic [WK_W-1:0] t;
		logic            take;
		always_comb begin
			t    = (f_s[j-1] << (B+1)) + (lhs_s[j-1] << (2*B));
			take = (t <= e_s[j-1]);
		end
		always_ff @(posedge clk) begin
			if (en[j]) begin
				e_s[j]   <= take ? e_s[j-1] - t : e_s[j-1];
				f_s[j]   <= take ? f_s[j-1] + (lhs_s[j-1] << B) : f_s[j-1];
				q_s[j]   <= q_s[j-1] | (DIST_BITS'(take) << B);
				lhs_s[j] <= lhs_s[j-1];
				deg_s[j] <= deg_s[j-1];
				sat_s[j] <= sat_s[j-1];
			end
		end
	end

	assign degenerate = deg_s[SEARCH_ST-1];
	assign saturated  = sat_s[SEARCH_ST-1];
	assign distance   = deg_s[SEARCH_ST-1] ? '0
		: (sat_s[SEARCH_ST-1] ? '1 : q_s[SEARCH_ST-1]);
endmodule

@@ src/point_to_line_distance_3d_unit.sv @@
`timescale 1ns / 1ps
// channel  handshake             word
// req      req_valid/req_stall   point_*, line_*, dir_* (signed Q16.16)
// rsp      rsp_valid/rsp_stall   distance (Q18.16), degenerate, saturated
//
// 3 cross-product stages, 3 squaring stages, a range check and one
// stage per distance bit. One word per cycle while rsp_stall is low.
// Reset clears only the valid bits. Each stage advances when empty or
// when the next one advances, so bubbles close up under a rsp stall.
module point_to_line_distance_3d_unit import pld3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  coord_t               point_x,
	input  coord_t               point_y,
	input  coord_t               point_z,
	input  coord_t               line_x,
	input  coord_t               line_y,
	input  coord_t               line_z,
	input  coord_t               dir_x,
	input  coord_t               dir_y,
	input  coord_t               dir_z,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [DIST_BITS-1:0] distance,
	output logic                 degenerate,
	output logic                 saturated
);
	logic [NST:1]   vld_s;
	logic [NST+1:1] en;
	mag_t            cmag_s3 [3];
	logic [SD_W-1:0] sd_s3, sd_s6;
	logic [SC_W-1:0] sc_s6;
	logic            deg_s3, deg_s6;

	always_comb begin
		en[NST+1] = !rsp_stall;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= req_valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign req_stall = !en[1];
	assign rsp_valid = vld_s[NST];

	pld3_cross u_cross (
		.clk, .en(en[3:1]),
		.point_x, .point_y, .point_z, .line_x, .line_y, .line_z,
		.dir_x, .dir_y, .dir_z,
		.cmag_s3, .sd_s3, .deg_s3
	);

	pld3_square u_square (
		.clk, .en(en[6:4]), .cmag_s3, .sd_s3, .deg_s3, .sc_s6, .sd_s6, .deg_s6
	);

	pld3_search u_search (
		.clk, .en(en[NST:FRONT_ST+1]), .sc_s6, .sd_s6, .deg_s6,
		.distance, .degenerate, .saturated
	);

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && degenerate |-> distance == '0 && !saturated)
		else $error("degenerate word with nonzero distance");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && saturated |-> distance == '1)
		else $error("saturated word not at maximum");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> vld_s[1])
		else $error("accepted word lost at entry");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NST-1] && !en[NST] |=> vld_s[NST-1] && vld_s[NST])
		else $error("word dropped behind a stall");
endmodule

@@ bench/pld3_checker.sv @@
`timescale 1ns / 1ps
module pld3_checker import pld3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  coord_t               point_x,
	input  coord_t               point_y,
	input  coord_t               point_z,
	input  coord_t               line_x,
	input  coord_t               line_y,
	input  coord_t               line_z,
	input  coord_t               dir_x,
	input  coord_t               dir_y,
	input  coord_t               dir_z,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  logic [DIST_BITS-1:0] distance,
	input  logic                 degenerate,
	input  logic                 saturated,
	output int                   fail_count,
	output int                   pending,
	output int                   rsp_count
);
	typedef struct packed {
		logic [DIST_BITS-1:0] dist_val;
		logic                 degen;
		logic                 sat;
	} dist_word_t;

	localparam int BIG = 512;

	dist_word_t expected_q[$];

	function automatic dist_word_t predict_distance(coord_t px, coord_t py, coord_t pz,
			coord_t rx, coord_t ry, coord_t rz, coord_t dx, coord_t dy, coord_t dz);
		logic signed [BIG-1:0] vx, vy, vz, cx, cy, cz, ddx, ddy, ddz;
		logic [BIG-1:0] sc, sd, lhs, rhs, q, t;
		dist_word_t w;
		vx = BIG'(rx) - BIG'(px);
		vy = BIG'(ry) - BIG'(py);
		vz = BIG'(rz) - BIG'(pz);
		ddx = BIG'(dx);
		ddy = BIG'(dy);
		ddz = BIG'(dz);
		cx = ddy * vz - ddz * vy;
		cy = ddz * vx - ddx * vz;
		cz = ddx * vy - ddy * vx;
		sc = cx * cx + cy * cy + cz * cz;
		sd = ddx * ddx + ddy * ddy + ddz * ddz;
		w = '0;
		if (sd == 0) begin
			w.degen = 1'b1;
			return w;
		end
		lhs = sd << SHL;
		rhs = sc << SHR;
		q = BIG'(1) << DIST_BITS;
		if (q * q * lhs <= rhs) begin
			w.dist_val = '1;
			w.sat = 1'b1;
			return w;
		end
		q = '0;
		for (int b = DIST_BITS - 1; b >= 0; b--) begin
			t = q | (BIG'(1) << b);
			if (t * t * lhs <= rhs)
				q = t;
		end
		w.dist_val = q[DIST_BITS-1:0];
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		rsp_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		dist_word_t e;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_count++;
				if (expected_q.size() == 0)
					report_mismatch("response word with nothing expected");
				else begin
					e = expected_q.pop_front();
					if (distance !== e.dist_val)
						report_mismatch($sformatf("distance got %h want %h", distance,
							e.dist_val));
					if (degenerate !== e.degen)
						report_mismatch($sformatf("degenerate got %b want %b", degenerate, e.degen));
					if (saturated !== e.sat)
						report_mismatch($sformatf("saturated got %b want %b", saturated, e.sat));
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(predict_distance(point_x, point_y, point_z,
					line_x, line_y, line_z, dir_x, dir_y, dir_z));
			pending = expected_q.size();
		end
	end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import pld3_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall, rsp_valid, degenerate, saturated;
	logic [DIST_BITS-1:0] distance;
	coord_t point_x = '0, point_y = '0, point_z = '0;
	coord_t line_x = '0, line_y = '0, line_z = '0;
	coord_t dir_x = '0, dir_y = '0, dir_z = '0;
	int fail_count, pending, rsp_count;
	int send_idle_pct = 15;
	int recv_idle_pct = 68;
	int sat_seen = 0, degen_seen = 0;

	always #5 clk = ~clk;

	point_to_line_distance_3d_unit uut (.*);

	pld3_checker chk (.*);

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			sat_seen += saturated;
			degen_seen += degenerate;
		end
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic coord_t rand_coord(input int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			2: return coord_t'($signed($urandom_range(0, 511)) - 256);
			default: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return 32'sh0001_0000;
				endcase
			end
		endcase
	endfunction

	// present one word and hold it until taken
	task automatic send_word(input coord_t c[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		{point_x, point_y, point_z} <= {c[0], c[1], c[2]};
		{line_x, line_y, line_z} <= {c[3], c[4], c[5]};
		{dir_x, dir_y, dir_z} <= {c[6], c[7], c[8]};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic send_random(input int n);
		coord_t c[9];
		int m;
		for (int k = 0; k < n; k++) begin
			m = $urandom_range(3);
			for (int i = 0; i < 9; i++)
				c[i] = rand_coord(($urandom_range(9) == 0) ? 3 : m);
			if ($urandom_range(19) == 0)
				{c[6], c[7], c[8]} = '0;
			send_word(c);
		end
	endtask

	initial begin
		coord_t c[9];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero direction, point on line, extremes, unit cases
		c = '{default: '0};
		send_word(c);
		c = '{0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0};
		send_word(c);
		c = '{0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0};
		send_word(c);
		c = '{0, 32'sh30000, 32'sh40000, 0, 0, 0, 32'sh20000, 0, 0};
		send_word(c);
		c = '{default: 32'sh7FFF_FFFF};
		send_word(c);
		c = '{default: 32'sh8000_0000};
		send_word(c);
		c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 1, 0, 0};
		send_word(c);
		c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_word(c);
		c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 1};
		send_word(c);
		c = '{0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
		send_word(c);
		c = '{1, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF};
		send_word(c);
		c = '{-1, -1, -1, 1, 1, 1, -1, 1, -1};
		send_word(c);
		send_random(250);
		send_idle_pct = 68;
		recv_idle_pct = 15;
		send_random(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(250);
		req_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("%0d distance words checked, %0d saturated, %0d degenerate",
			rsp_count, sat_seen, degen_seen);
		$display("phases: light/heavy, heavy/light and no idling on both channels");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
